// ===== rtl/rsd_pkg.sv =====
// Shared widths, register codes, stage positions and constant tables of the decision core.
`timescale 1ns / 1ps
`default_nettype none
package rsd_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int SAT_SH     = 15;
  localparam int QUOT_W     = SAT_SH + FRAC_BITS;
  localparam int AW         = QUOT_W + 1;
  localparam int L_W        = FRAC_BITS + 10;
  localparam int SW         = AW + 4;

  localparam int ZV_W       = 64;
  localparam int VV_W       = 63;
  localparam int U_W        = 63;
  localparam int MODE_W     = 2;
  localparam int VAR_W      = 62;
  localparam int M_W        = 32;
  localparam int NUM_W      = 65;
  localparam int DEN_W      = 63;
  localparam int MAN_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_SIGN    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BIMODAL = 2'd2;

  localparam logic [31:0] LOG2E_HI = 32'hB8AA3B29;
  localparam logic [31:0] LOG2E_LO = 32'h5C17F0BC;

  // pipeline positions, counted from the entry register
  localparam int T_LG   = FRAC_BITS;
  localparam int T_L    = T_LG + 1;
  localparam int T_DIV  = QUOT_W + 1;
  localparam int T_PROD = T_DIV + 1;
  localparam int T_AB   = T_PROD + 1;
  localparam int T_W    = T_AB + FRAC_BITS + 1;
  localparam int T_SP   = T_W + FRAC_BITS;
  localparam int T_OUT  = T_SP + 1;

  typedef logic [FRAC_BITS-1:0][31:0] exp_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xx;
    r  = '0;
    b  = 64'h4000_0000_0000_0000;
    xx = x;
    for (int i = 0; i < 32; i++) begin
      if (xx >= r + b) begin
        xx = xx - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // factor 2^(-2^-(k+1)) in Q0.32 for each fraction bit
  function automatic exp_tab_t exp_table();
    exp_tab_t    t;
    logic [63:0] c;
    c = 64'h8000_0000;
    for (int k = 0; k < FRAC_BITS; k++) begin
      c    = isqrt64(c << 32);
      t[k] = c[31:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_C = exp_table();

endpackage
`default_nettype wire

// ===== rtl/rsd_in_if.sv =====
// Candidate channel: inner products and random word.
`timescale 1ns / 1ps
`default_nettype none
interface rsd_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [rsd_pkg::ZV_W-1:0] inner_zv;
  logic        [rsd_pkg::VV_W-1:0] inner_vv;
  logic        [rsd_pkg::U_W-1:0]  random_word;
  modport source (output valid, inner_zv, inner_vv, random_word, input ready);
  modport sink   (input valid, inner_zv, inner_vv, random_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/rsd_out_if.sv =====
// Result channel: reject flag.
`timescale 1ns / 1ps
`default_nettype none
interface rsd_out_if;
  logic valid;
  logic ready;
  logic rejected;
  modport source (output valid, rejected, input ready);
  modport sink   (input valid, rejected, output ready);
endinterface
`default_nettype wire

// ===== rtl/rsd_cfg_if.sv =====
// Configuration write channel: register index and data.
`timescale 1ns / 1ps
`default_nettype none
interface rsd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rsd_pkg::CFG_IDX_W-1:0]     index;
  logic [rsd_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rejection_sampling_decision_core.sv =====
// Top level of the rejection-sampling decision core.
// Throughput: one candidate per cycle unless the pipeline is held; depth is set
// by the 39-step divider chain and the two 24-step multiply chains (power-of-two
// factors, then log of 1 + 2^-2B).
// Whole pipeline holds while the result register is full and not taken.
// Reset (synchronous): clears all valid bits; mode 0, variance 1, rate 1.0.
`timescale 1ns / 1ps
`default_nettype none
module rejection_sampling_decision_core (
  input  logic      clk,
  input  logic      rst,
  rsd_in_if.sink    cand,
  rsd_out_if.source result,
  rsd_cfg_if.sink   cfg
);
  import rsd_pkg::*;

  typedef struct packed {
    logic forced;
    logic fval;
    logic bim;
    logic eneg;
  } side_t;

  typedef struct packed {
    logic [AW-1:0] a;
    logic [AW-1:0] b;
  } ab_t;

  typedef struct packed {
    logic [32:0]          p;
    logic [FRAC_BITS-1:0] tf;
    logic                 big;
    logic [4:0]           sh;
  } exp_t;

  localparam int TI_W = AW - FRAC_BITS + 1;

  logic [MODE_W-1:0] mode;
  logic [VAR_W-1:0]  variance;
  logic [M_W-1:0]    rate_m;

  logic en;
  logic v [T_OUT+1];

  // entry stage
  side_t            side_d [T_SP+1];
  logic [5:0]       nu_d   [T_LG+1];
  logic [5:0]       nm_d   [T_LG+1];
  logic [MAN_W-1:0] man_u;
  logic [MAN_W-1:0] man_m;
  logic [NUM_W-1:0] num_a;
  logic [NUM_W-1:0] num_b;

  side_t            side_next;
  logic [5:0]       nu_next;
  logic [5:0]       nm_next;
  logic [MAN_W-1:0] man_u_next;
  logic [MAN_W-1:0] man_m_next;
  logic [NUM_W-1:0] num_a_next;
  logic [NUM_W-1:0] num_b_next;

  logic [FRAC_BITS-1:0] fu;
  logic [FRAC_BITS-1:0] fm;
  logic [FRAC_BITS-1:0] fsp;
  logic [AW-1:0]        qa;
  logic [AW-1:0]        qb;

  logic [L_W-1:0]   l_d  [T_L:T_SP];
  logic [L_W-1:0]   l_next;
  logic [AW+31:0]   pa1, pa0, pb1, pb0;
  ab_t              ab_d [T_AB:T_SP];
  ab_t              ab_next;
  exp_t             ex      [FRAC_BITS];
  exp_t             ex_next [FRAC_BITS];
  exp_t             ex_src  [FRAC_BITS];
  logic             one_d   [T_W:T_SP];
  logic             one_next;
  logic [MAN_W-1:0] sp_man;
  logic [MAN_W-1:0] sp_man_next;
  logic             rejected_r;
  logic             rej_next;

  function automatic logic [5:0] msb_idx(input logic [63:0] x);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 6'(i);
    end
    return n;
  endfunction

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= '0;
      variance <= VAR_W'(1);
      rate_m   <= M_W'(1) << FRAC_BITS;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MODE: mode     <= cfg.data[MODE_W-1:0];
        REG_VAR:  variance <= cfg.data[VAR_W-1:0];
        REG_RATE: rate_m   <= cfg.data[M_W-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  assign en         = !v[T_OUT] || result.ready;
  assign cand.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= T_OUT; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[0] <= cand.valid;
      for (int i = 1; i <= T_OUT; i++) v[i] <= v[i-1];
    end
  end

  // entry: normalize, form numerators, early decisions
  always_comb begin
    logic [63:0] zv;
    logic [63:0] zmag;
    logic [63:0] vv64;
    logic [63:0] tz;
    logic [63:0] u64;
    logic [63:0] m64;
    logic [63:0] su;
    logic [63:0] sm;
    logic        neg;
    zv   = cand.inner_zv;
    neg  = zv[63];
    zmag = neg ? (64'd0 - zv) : zv;
    vv64 = {1'b0, cand.inner_vv};
    tz   = {zv[62:0], 1'b0};
    u64  = {1'b0, cand.random_word};
    m64  = {32'd0, rate_m};

    nu_next    = msb_idx(u64);
    nm_next    = msb_idx(m64);
    su         = u64 << (6'd63 - nu_next);
    sm         = m64 << (6'd63 - nm_next);
    man_u_next = su[63:32];
    man_m_next = sm[63:32];

    side_next.bim    = (mode == MODE_BIMODAL);
    side_next.fval   = (mode == MODE_SIGN) && neg;
    side_next.forced = side_next.fval || (u64 == '0) || (rate_m == '0);
    side_next.eneg   = 1'b0;
    if (side_next.bim) begin
      num_a_next = {2'b00, cand.inner_vv};
    end else if (neg) begin
      num_a_next = {zmag, 1'b0} + {2'b00, cand.inner_vv};
    end else if (vv64 >= tz) begin
      num_a_next = {1'b0, vv64 - tz};
    end else begin
      num_a_next     = {1'b0, tz - vv64};
      side_next.eneg = 1'b1;
    end
    num_b_next = {1'b0, zmag};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side_next;
      nu_d[0]   <= nu_next;
      nm_d[0]   <= nm_next;
      man_u     <= man_u_next;
      man_m     <= man_m_next;
      num_a     <= num_a_next;
      num_b     <= num_b_next;
      for (int i = 1; i <= T_SP; i++) side_d[i] <= side_d[i-1];
      for (int i = 1; i <= T_LG; i++) begin
        nu_d[i] <= nu_d[i-1];
        nm_d[i] <= nm_d[i-1];
      end
    end
  end

  rsd_lg u_lg_u (.clk(clk), .en(en), .man(man_u), .frac(fu));
  rsd_lg u_lg_m (.clk(clk), .en(en), .man(man_m), .frac(fm));

  rsd_div u_div_a (.clk(clk), .en(en), .num(num_a), .den({variance, 1'b0}), .quo(qa));
  rsd_div u_div_b (.clk(clk), .en(en), .num(num_b), .den({1'b0, variance}), .quo(qb));

  // log of u*M less the 2^63 and 2^24 scales
  always_comb begin
    logic [7:0] ip;
    ip     = {2'b00, nu_d[T_LG]} + {2'b00, nm_d[T_LG]} - 8'd87;
    l_next = {{(L_W-8-FRAC_BITS){ip[7]}}, ip, {FRAC_BITS{1'b0}}}
           + L_W'(fu) + L_W'(fm);
  end

  // quotient times log2(e), two partial products then sum
  always_comb begin
    logic [AW+63:0] sa;
    logic [AW+63:0] sb;
    sa        = {pa1, 32'd0} + (AW+64)'(pa0);
    sb        = {pb1, 32'd0} + (AW+64)'(pb0);
    ab_next.a = sa[63 +: AW];
    ab_next.b = sb[63 +: AW];
  end

  // 2^-(2B): one fraction bit per stage
  always_comb begin
    logic [TI_W-1:0] ti;
    logic [64:0]     prod;
    ti               = ab_d[T_AB].b[AW-1:FRAC_BITS-1];
    ex_src[0].p      = 33'h1_0000_0000;
    ex_src[0].tf     = {ab_d[T_AB].b[FRAC_BITS-2:0], 1'b0};
    ex_src[0].big    = |ti[TI_W-1:5];
    ex_src[0].sh     = ti[4:0];
    for (int k = 1; k < FRAC_BITS; k++) ex_src[k] = ex[k-1];
    for (int k = 0; k < FRAC_BITS; k++) begin
      prod       = 65'(ex_src[k].p) * 65'(EXP_C[k]);
      ex_next[k] = ex_src[k];
      if (ex_src[k].tf[FRAC_BITS-1]) ex_next[k].p = prod[64:32];
      ex_next[k].tf = ex_src[k].tf << 1;
    end
  end

  // mantissa of 1 + w in Q1.31
  always_comb begin
    logic [32:0] w;
    logic [32:0] m;
    w           = ex[FRAC_BITS-1].big ? 33'd0 : (ex[FRAC_BITS-1].p >> ex[FRAC_BITS-1].sh);
    m           = 33'h0_8000_0000 + (w >> 1);
    one_next    = m[32];
    sp_man_next = m[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_d[T_L] <= l_next;
      for (int i = T_L + 1; i <= T_SP; i++) l_d[i] <= l_d[i-1];
      pa1 <= (AW+32)'(qa) * (AW+32)'(LOG2E_HI);
      pa0 <= (AW+32)'(qa) * (AW+32)'(LOG2E_LO);
      pb1 <= (AW+32)'(qb) * (AW+32)'(LOG2E_HI);
      pb0 <= (AW+32)'(qb) * (AW+32)'(LOG2E_LO);
      ab_d[T_AB] <= ab_next;
      for (int i = T_AB + 1; i <= T_SP; i++) ab_d[i] <= ab_d[i-1];
      for (int k = 0; k < FRAC_BITS; k++) ex[k] <= ex_next[k];
      one_d[T_W] <= one_next;
      for (int i = T_W + 1; i <= T_SP; i++) one_d[i] <= one_d[i-1];
      sp_man <= sp_man_next;
    end
  end

  rsd_lg u_lg_sp (.clk(clk), .en(en), .man(sp_man), .frac(fsp));

  // final decision
  always_comb begin
    logic [SW-1:0] lx;
    logic [SW-1:0] ax;
    logic [SW-1:0] bx;
    logic [SW-1:0] spx;
    logic [SW-1:0] tb;
    logic [SW-1:0] es;
    logic          rej_b;
    logic          rej_s;
    lx    = {{(SW-L_W){l_d[T_SP][L_W-1]}}, l_d[T_SP]};
    ax    = SW'(ab_d[T_SP].a);
    bx    = SW'(ab_d[T_SP].b);
    spx   = one_d[T_SP] ? (SW'(1) << FRAC_BITS) : SW'(fsp);
    tb    = lx - ax + bx + spx - (SW'(1) << FRAC_BITS);
    rej_b = !tb[SW-1] && (tb != '0);
    es    = side_d[T_SP].eneg ? (SW'(0) - ax) : ax;
    rej_s = $signed(lx) > $signed(es);
    if (side_d[T_SP].forced) begin
      rej_next = side_d[T_SP].fval;
    end else if (side_d[T_SP].bim) begin
      rej_next = rej_b;
    end else begin
      rej_next = rej_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) rejected_r <= rej_next;
  end

  assign result.valid    = v[T_OUT];
  assign result.rejected = rejected_r;

endmodule
`default_nettype wire

// ===== rtl/rsd_lg.sv =====
// Pipelined fractional log2 by repeated squaring of a Q1.31 mantissa, one bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rsd_lg (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rsd_pkg::MAN_W-1:0]     man,
  output logic [rsd_pkg::FRAC_BITS-1:0] frac
);
  import rsd_pkg::*;

  logic [MAN_W-1:0]     ms     [FRAC_BITS];
  logic [FRAC_BITS-1:0] fs     [FRAC_BITS];
  logic [MAN_W-1:0]     src_m  [FRAC_BITS];
  logic [FRAC_BITS-1:0] src_f  [FRAC_BITS];
  logic [MAN_W-1:0]     ms_next[FRAC_BITS];
  logic [FRAC_BITS-1:0] fs_next[FRAC_BITS];

  always_comb begin
    src_m[0] = man;
    src_f[0] = '0;
    for (int k = 1; k < FRAC_BITS; k++) begin
      src_m[k] = ms[k-1];
      src_f[k] = fs[k-1];
    end
  end

  always_comb begin
    logic [2*MAN_W-1:0] sq;
    for (int k = 0; k < FRAC_BITS; k++) begin
      sq = (2*MAN_W)'(src_m[k]) * (2*MAN_W)'(src_m[k]);
      if (sq[2*MAN_W-1]) begin
        ms_next[k] = sq[2*MAN_W-1:MAN_W];
      end else begin
        ms_next[k] = sq[2*MAN_W-2:MAN_W-1];
      end
      fs_next[k] = {src_f[k][FRAC_BITS-2:0], sq[2*MAN_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < FRAC_BITS; k++) begin
        ms[k] <= ms_next[k];
        fs[k] <= fs_next[k];
      end
    end
  end

  assign frac = fs[FRAC_BITS-1];

endmodule
`default_nettype wire

// ===== rtl/rsd_div.sv =====
// Pipelined saturating restoring divider: floor(num * 2^F / den) capped at 2^(15+F).
`timescale 1ns / 1ps
`default_nettype none
module rsd_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rsd_pkg::NUM_W-1:0] num,
  input  logic [rsd_pkg::DEN_W-1:0] den,
  output logic [rsd_pkg::AW-1:0]    quo
);
  import rsd_pkg::*;

  typedef struct packed {
    logic              sat;
    logic              zro;
    logic [DEN_W-1:0]  rem;
    logic [SAT_SH-1:0] nl;
    logic [QUOT_W-1:0] q;
  } div_st_t;

  div_st_t st      [QUOT_W+1];
  div_st_t st_next [QUOT_W+1];

  always_comb begin
    logic [DEN_W:0] t;
    logic           ge;
    st_next[0].zro = (den == '0) && (num == '0);
    st_next[0].sat = (den == '0) ? (num != '0)
                   : ((DEN_W+SAT_SH)'(num) >= {den, {SAT_SH{1'b0}}});
    st_next[0].rem = DEN_W'(num >> SAT_SH);
    st_next[0].nl  = num[SAT_SH-1:0];
    st_next[0].q   = '0;
    for (int k = 1; k <= QUOT_W; k++) begin
      t  = {st[k-1].rem, st[k-1].nl[SAT_SH-1]};
      ge = t >= {1'b0, den};
      st_next[k].zro = st[k-1].zro;
      st_next[k].sat = st[k-1].sat;
      st_next[k].rem = ge ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
      st_next[k].nl  = st[k-1].nl << 1;
      st_next[k].q   = {st[k-1].q[QUOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= QUOT_W; k++) begin
        st[k] <= st_next[k];
      end
    end
  end

  always_comb begin
    if (st[QUOT_W].zro) begin
      quo = '0;
    end else if (st[QUOT_W].sat) begin
      quo = AW'(1) << QUOT_W;
    end else begin
      quo = {1'b0, st[QUOT_W].q};
    end
  end

endmodule
`default_nettype wire
